// ----- rtl/cgtb_pkg.sv -----
// shared types and constants for the csr graph transpose builder
// no dependencies
package cgtb_pkg;

   localparam int MAX_NODES_DEF = 1024;
   localparam int MAX_EDGES_DEF = 4096;
   localparam int NODE_W  = 10;
   localparam int COUNT_W = 13;

   localparam logic [1:0] FUNC_NODE  = 2'd0;
   localparam logic [1:0] FUNC_EDGE  = 2'd1;
   localparam logic [1:0] FUNC_BUILD = 2'd2;
   localparam logic [1:0] FUNC_READ  = 2'd3;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_RANGE     = 2'd1;
   localparam logic [1:0] ST_FULL      = 2'd2;
   localparam logic [1:0] ST_NOT_BUILT = 2'd3;

   localparam logic [7:0] CSR_NODE_COUNT    = 8'd0;
   localparam logic [7:0] CSR_BUILD_INVERSE = 8'd1;

   typedef struct packed {
      logic [1:0]  func;
      logic [9:0]  node_id;
      logic [12:0] link_count;
      logic [9:0]  target;
      logic [11:0] position;
   } req_type;

   typedef struct packed {
      logic [12:0] out_degree;
      logic [12:0] in_degree;
      logic [12:0] offset;
      logic [9:0]  neighbor;
      logic [12:0] edge_total;
      logic [1:0]  status;
   } rsp_type;

endpackage

// ----- rtl/cgtb_ram.sv -----
// simple dual port ram, one write port and one registered read port
// no dependencies
module cgtb_ram #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 13
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ----- rtl/csr_graph_transpose_builder.sv -----
// top level: degree counts, prefix offsets and transpose scatter over block rams
// depends on cgtb_pkg and cgtb_ram
// node, edge, read and non-inverting build requests: request and ram read registered
// at start, response formed in exec, strobe registered; new requests wait for idle
// inverting build: prefix pass (read, write per node), then scatter pass (read,
// cursor, write per edge; an out of range destination skips the write)
// the receiver cannot stall: each response is shown for one cycle on rsp_strobe
// after reset busy stays high while the degree rams are cleared
module csr_graph_transpose_builder #(
   parameter int MAX_NODES = cgtb_pkg::MAX_NODES_DEF,
   parameter int MAX_EDGES = cgtb_pkg::MAX_EDGES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  cgtb_pkg::req_type req_item,
   output logic              rsp_strobe,
   output cgtb_pkg::rsp_type rsp_item,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [7:0]        csr_index,
   input  logic [10:0]       csr_data
);

   localparam int NAW = $clog2(MAX_NODES);
   localparam int NCW = $clog2(MAX_NODES + 1);
   localparam int EAW = $clog2(MAX_EDGES);
   localparam int ECW = $clog2(MAX_EDGES + 1);
   localparam int NW  = cgtb_pkg::NODE_W;
   localparam int CW  = cgtb_pkg::COUNT_W;

   typedef enum logic [7:0] {
      S_CLEAR  = 8'b0000_0001,
      S_IDLE   = 8'b0000_0010,
      S_EXEC   = 8'b0000_0100,
      S_PRE_RD = 8'b0000_1000,
      S_PRE_WR = 8'b0001_0000,
      S_SC_RD  = 8'b0010_0000,
      S_SC_CUR = 8'b0100_0000,
      S_SC_WR  = 8'b1000_0000
   } state_type;

   state_type         state_ff, state_in;
   cgtb_pkg::req_type req_ff, req_in;
   cgtb_pkg::rsp_type rsp_ff, rsp_in;
   logic              strobe_ff, strobe_in;
   logic [ECW-1:0]    cnt_ff, cnt_in;
   logic [NW-1:0]     src_ff, src_in;
   logic              ready_ff, ready_in;
   logic [ECW-1:0]    total_ff, total_in;
   logic [ECW-1:0]    run_ff, run_in;
   logic [NCW-1:0]    idx_ff, idx_in;
   logic [ECW-1:0]    eidx_ff, eidx_in;
   logic [NW-1:0]     sc_src_ff, sc_src_in;
   logic [NAW-1:0]    sc_dst_ff, sc_dst_in;
   logic [10:0]       node_count_ff, node_count_in;
   logic              build_inv_ff, build_inv_in;

   logic [NCW-1:0]    n;
   logic              accept;
   logic [ECW-1:0]    sum;

   logic           od_we;
   logic [NAW-1:0] od_wa, od_ra;
   logic [CW-1:0]  od_wd, od_rd;
   logic           id_we;
   logic [NAW-1:0] id_wa, id_ra;
   logic [ECW-1:0] id_wd, id_rd;
   logic           of_we;
   logic [NCW-1:0] of_wa, of_ra;
   logic [ECW-1:0] of_wd, of_rd;
   logic           cu_we;
   logic [NAW-1:0] cu_wa, cu_ra;
   logic [ECW-1:0] cu_wd, cu_rd;
   logic           ed_we;
   logic [EAW-1:0] ed_wa, ed_ra;
   logic [2*NW-1:0] ed_wd, ed_rd;
   logic           nb_we;
   logic [EAW-1:0] nb_wa, nb_ra;
   logic [NW-1:0]  nb_wd, nb_rd;

   cgtb_ram #(.DEPTH(MAX_NODES), .WIDTH(CW)) u_out_deg (
      .clock(clock), .wr_en(od_we), .wr_addr(od_wa), .wr_data(od_wd),
      .rd_addr(od_ra), .rd_data(od_rd));
   cgtb_ram #(.DEPTH(MAX_NODES), .WIDTH(ECW)) u_in_deg (
      .clock(clock), .wr_en(id_we), .wr_addr(id_wa), .wr_data(id_wd),
      .rd_addr(id_ra), .rd_data(id_rd));
   cgtb_ram #(.DEPTH(MAX_NODES + 1), .WIDTH(ECW)) u_offset (
      .clock(clock), .wr_en(of_we), .wr_addr(of_wa), .wr_data(of_wd),
      .rd_addr(of_ra), .rd_data(of_rd));
   cgtb_ram #(.DEPTH(MAX_NODES), .WIDTH(ECW)) u_cursor (
      .clock(clock), .wr_en(cu_we), .wr_addr(cu_wa), .wr_data(cu_wd),
      .rd_addr(cu_ra), .rd_data(cu_rd));
   cgtb_ram #(.DEPTH(MAX_EDGES), .WIDTH(2 * NW)) u_edge (
      .clock(clock), .wr_en(ed_we), .wr_addr(ed_wa), .wr_data(ed_wd),
      .rd_addr(ed_ra), .rd_data(ed_rd));
   cgtb_ram #(.DEPTH(MAX_EDGES), .WIDTH(NW)) u_neighbor (
      .clock(clock), .wr_en(nb_we), .wr_addr(nb_wa), .wr_data(nb_wd),
      .rd_addr(nb_ra), .rd_data(nb_rd));

   assign busy       = (state_ff != S_IDLE);
   assign accept     = start && !busy;
   assign csr_ready  = 1'b1;
   assign rsp_strobe = strobe_ff;
   assign rsp_item   = rsp_ff;
   assign n = (32'(node_count_ff) < MAX_NODES) ? NCW'(node_count_ff) : NCW'(MAX_NODES);
   assign sum = run_ff + id_rd;

   // read addresses
   assign od_ra = NAW'(req_item.node_id);
   assign id_ra = (state_ff == S_IDLE)
                ? ((req_item.func == cgtb_pkg::FUNC_EDGE) ? NAW'(req_item.target)
                                                          : NAW'(req_item.node_id))
                : NAW'(idx_ff);
   assign of_ra = NCW'(req_item.node_id);
   assign nb_ra = EAW'(req_item.position);
   assign ed_ra = EAW'(eidx_ff);
   assign cu_ra = NAW'(ed_rd[NW-1:0]);

   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      rsp_in        = rsp_ff;
      strobe_in     = 1'b0;
      cnt_in        = cnt_ff;
      src_in        = src_ff;
      ready_in      = ready_ff;
      total_in      = total_ff;
      run_in        = run_ff;
      idx_in        = idx_ff;
      eidx_in       = eidx_ff;
      sc_src_in     = sc_src_ff;
      sc_dst_in     = sc_dst_ff;
      node_count_in = node_count_ff;
      build_inv_in  = build_inv_ff;
      od_we = 1'b0; od_wa = NAW'(idx_ff); od_wd = '0;
      id_we = 1'b0; id_wa = NAW'(idx_ff); id_wd = '0;
      of_we = 1'b0; of_wa = '0;           of_wd = '0;
      cu_we = 1'b0; cu_wa = NAW'(idx_ff); cu_wd = run_ff;
      ed_we = 1'b0; ed_wa = EAW'(cnt_ff); ed_wd = {src_ff, req_ff.target};
      nb_we = 1'b0; nb_wa = EAW'(cu_rd);  nb_wd = sc_src_ff;

      unique case (state_ff)
         S_CLEAR: begin
            od_we = 1'b1;
            id_we = 1'b1;
            if (32'(idx_ff) == MAX_NODES - 1) begin
               state_in = S_IDLE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         S_IDLE: begin
            if (accept) begin
               req_in   = req_item;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            rsp_in        = '0;
            rsp_in.status = cgtb_pkg::ST_OK;
            state_in      = S_IDLE;
            strobe_in     = 1'b1;
            case (req_ff.func)
               cgtb_pkg::FUNC_NODE: begin
                  if (32'(req_ff.node_id) >= 32'(n)) begin
                     rsp_in.status = cgtb_pkg::ST_RANGE;
                  end else begin
                     od_we  = 1'b1;
                     od_wa  = NAW'(req_ff.node_id);
                     od_wd  = req_ff.link_count;
                     src_in = req_ff.node_id;
                  end
               end
               cgtb_pkg::FUNC_EDGE: begin
                  if (32'(req_ff.target) >= 32'(n)) begin
                     rsp_in.status = cgtb_pkg::ST_RANGE;
                  end else if (32'(cnt_ff) >= MAX_EDGES) begin
                     rsp_in.status = cgtb_pkg::ST_FULL;
                  end else begin
                     id_we    = 1'b1;
                     id_wa    = NAW'(req_ff.target);
                     id_wd    = id_rd + 1'b1;
                     ed_we    = 1'b1;
                     cnt_in   = cnt_ff + 1'b1;
                     ready_in = 1'b0;
                  end
               end
               cgtb_pkg::FUNC_BUILD: begin
                  if (!build_inv_ff) begin
                     ready_in = 1'b0;
                  end else begin
                     strobe_in = 1'b0;
                     of_we     = 1'b1;
                     run_in    = '0;
                     idx_in    = '0;
                     eidx_in   = '0;
                     if (n == '0) begin
                        if (cnt_ff == '0) begin
                           strobe_in = 1'b1;
                           ready_in  = 1'b1;
                           total_in  = '0;
                        end else begin
                           state_in = S_SC_RD;
                        end
                     end else begin
                        state_in = S_PRE_RD;
                     end
                  end
               end
               default: begin
                  if (32'(req_ff.node_id) >= 32'(n)) begin
                     rsp_in.status = cgtb_pkg::ST_RANGE;
                  end else begin
                     rsp_in.out_degree = od_rd;
                     rsp_in.in_degree  = CW'(id_rd);
                     if (!ready_ff) begin
                        rsp_in.status = cgtb_pkg::ST_NOT_BUILT;
                     end else begin
                        rsp_in.offset = CW'(of_rd);
                        if (32'(req_ff.position) < 32'(total_ff)) begin
                           rsp_in.neighbor = nb_rd;
                        end
                     end
                  end
               end
            endcase
         end
         S_PRE_RD: begin
            state_in = S_PRE_WR;
         end
         S_PRE_WR: begin
            of_we  = 1'b1;
            of_wa  = idx_ff + 1'b1;
            of_wd  = sum;
            cu_we  = 1'b1;
            run_in = sum;
            if (idx_ff + 1'b1 == n) begin
               if (cnt_ff == '0) begin
                  state_in  = S_IDLE;
                  strobe_in = 1'b1;
                  ready_in  = 1'b1;
                  total_in  = sum;
               end else begin
                  state_in = S_SC_RD;
               end
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = S_PRE_RD;
            end
         end
         S_SC_RD: begin
            state_in = S_SC_CUR;
         end
         S_SC_CUR: begin
            sc_src_in = ed_rd[2*NW-1:NW];
            sc_dst_in = NAW'(ed_rd[NW-1:0]);
            if (32'(ed_rd[NW-1:0]) < 32'(n)) begin
               state_in = S_SC_WR;
            end else if (eidx_ff + 1'b1 == cnt_ff) begin
               state_in  = S_IDLE;
               strobe_in = 1'b1;
               ready_in  = 1'b1;
               total_in  = run_ff;
            end else begin
               eidx_in  = eidx_ff + 1'b1;
               state_in = S_SC_RD;
            end
         end
         S_SC_WR: begin
            if (32'(cu_rd) < MAX_EDGES) begin
               nb_we = 1'b1;
               cu_we = 1'b1;
               cu_wa = sc_dst_ff;
               cu_wd = cu_rd + 1'b1;
            end
            if (eidx_ff + 1'b1 == cnt_ff) begin
               state_in  = S_IDLE;
               strobe_in = 1'b1;
               ready_in  = 1'b1;
               total_in  = run_ff;
            end else begin
               eidx_in  = eidx_ff + 1'b1;
               state_in = S_SC_RD;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (strobe_in) begin
         rsp_in.edge_total = CW'(cnt_in);
      end

      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            cgtb_pkg::CSR_NODE_COUNT: begin
               node_count_in = csr_data;
               ready_in      = 1'b0;
            end
            cgtb_pkg::CSR_BUILD_INVERSE: begin
               build_inv_in = csr_data[0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         strobe_ff     <= 1'b0;
         cnt_ff        <= '0;
         src_ff        <= '0;
         ready_ff      <= 1'b0;
         idx_ff        <= '0;
         node_count_ff <= 11'd1024;
         build_inv_ff  <= 1'b1;
      end else begin
         state_ff      <= state_in;
         strobe_ff     <= strobe_in;
         cnt_ff        <= cnt_in;
         src_ff        <= src_in;
         ready_ff      <= ready_in;
         idx_ff        <= idx_in;
         node_count_ff <= node_count_in;
         build_inv_ff  <= build_inv_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff    <= req_in;
      rsp_ff    <= rsp_in;
      total_ff  <= total_in;
      run_ff    <= run_in;
      eidx_ff   <= eidx_in;
      sc_src_ff <= sc_src_in;
      sc_dst_ff <= sc_dst_in;
   end

   a_strobe_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("back to back responses");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy && !rsp_strobe)
      else $error("request accepted without going busy");

   a_clear_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR) |-> (!rsp_strobe && cnt_ff == '0))
      else $error("activity during clearing pass");

   a_edge_bound: assert property (@(posedge clock) disable iff (reset)
      32'(cnt_ff) <= MAX_EDGES)
      else $error("edge count beyond store");

endmodule

// ----- bench/testbench.sv -----
// self-checking testbench for csr_graph_transpose_builder
// depends on cgtb_pkg and the rtl; predicts each response and compares in order
`timescale 1ns / 100ps

module testbench;

   typedef enum {PEND_REQ, PEND_CSR, PEND_DRAIN} pend_kind_type;
   typedef struct {
      pend_kind_type     kind;
      cgtb_pkg::req_type req;
      logic [7:0]        index;
      logic [10:0]       data;
   } pend_type;

   logic              clock = 0;
   logic              reset = 1;
   logic              start = 0;
   logic              busy;
   cgtb_pkg::req_type req_item = '0;
   logic              rsp_strobe;
   cgtb_pkg::rsp_type rsp_item;
   logic              csr_valid = 0;
   logic              csr_ready;
   logic [7:0]        csr_index = '0;
   logic [10:0]       csr_data = '0;

   pend_type          pending[$];
   cgtb_pkg::rsp_type expected_rsp[$];
   int                mismatches = 0;
   int                gap_cycles = 0;

   // mirror of the graph state
   logic [12:0] out_deg[cgtb_pkg::MAX_NODES_DEF];
   logic [12:0] in_deg[cgtb_pkg::MAX_NODES_DEF];
   logic [12:0] offsets[cgtb_pkg::MAX_NODES_DEF + 1];
   logic [12:0] cursor[cgtb_pkg::MAX_NODES_DEF];
   logic [9:0]  edge_src[cgtb_pkg::MAX_EDGES_DEF];
   logic [9:0]  edge_dst[cgtb_pkg::MAX_EDGES_DEF];
   logic [9:0]  neighbors[cgtb_pkg::MAX_EDGES_DEF];
   int          edge_count = 0;
   logic [9:0]  cur_source = '0;
   bit          inverse_valid = 0;
   logic [10:0] node_cnt = 11'd1024;
   bit          invert_on = 1;

   // generator side bookkeeping
   int gen_nodes = 1024;
   int gen_edges = 0;

   csr_graph_transpose_builder DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_item(req_item),
      .rsp_strobe(rsp_strobe), .rsp_item(rsp_item), .csr_valid(csr_valid),
      .csr_ready(csr_ready), .csr_index(csr_index), .csr_data(csr_data)
   );

   always #5 clock = ~clock;

   function automatic int nodes_active();
      return (node_cnt < cgtb_pkg::MAX_NODES_DEF) ? int'(node_cnt) : cgtb_pkg::MAX_NODES_DEF;
   endfunction

   function automatic void write_register(logic [7:0] index, logic [10:0] data);
      if (index == cgtb_pkg::CSR_NODE_COUNT) begin
         node_cnt = data;
         inverse_valid = 0;
      end else if (index == cgtb_pkg::CSR_BUILD_INVERSE) begin
         invert_on = data[0];
      end
   endfunction

   function automatic void build_transpose(int n);
      int run;
      int p;
      run = 0;
      offsets[0] = '0;
      for (int v = 0; v < n; v++) begin
         run += in_deg[v];
         offsets[v + 1] = 13'(run);
         cursor[v] = offsets[v];
      end
      for (int e = 0; e < edge_count; e++) begin
         if (edge_dst[e] < n) begin
            p = cursor[edge_dst[e]];
            if (p < cgtb_pkg::MAX_EDGES_DEF) begin
               neighbors[p] = edge_src[e];
               cursor[edge_dst[e]] = 13'(p + 1);
            end
         end
      end
      inverse_valid = 1;
   endfunction

   function automatic cgtb_pkg::rsp_type predict_graph_op(cgtb_pkg::req_type r);
      cgtb_pkg::rsp_type o;
      int n;
      o = '0;
      n = nodes_active();
      case (r.func)
         cgtb_pkg::FUNC_NODE: begin
            if (r.node_id >= n) o.status = cgtb_pkg::ST_RANGE;
            else begin
               out_deg[r.node_id] = r.link_count;
               cur_source = r.node_id;
            end
         end
         cgtb_pkg::FUNC_EDGE: begin
            if (r.target >= n) o.status = cgtb_pkg::ST_RANGE;
            else if (edge_count >= cgtb_pkg::MAX_EDGES_DEF) o.status = cgtb_pkg::ST_FULL;
            else begin
               in_deg[r.target] = 13'(in_deg[r.target] + 1);
               edge_src[edge_count] = cur_source;
               edge_dst[edge_count] = r.target;
               edge_count++;
               inverse_valid = 0;
            end
         end
         cgtb_pkg::FUNC_BUILD: begin
            if (invert_on) build_transpose(n);
            else inverse_valid = 0;
         end
         default: begin
            if (r.node_id >= n) o.status = cgtb_pkg::ST_RANGE;
            else begin
               o.out_degree = out_deg[r.node_id];
               o.in_degree = in_deg[r.node_id];
               if (!inverse_valid) o.status = cgtb_pkg::ST_NOT_BUILT;
               else begin
                  o.offset = offsets[r.node_id];
                  if (r.position < offsets[n]) o.neighbor = neighbors[r.position];
               end
            end
         end
      endcase
      o.edge_total = 13'(edge_count);
      return o;
   endfunction

   // driver
   always @(posedge clock) begin
      logic next_start;
      logic next_csr;
      if (reset) begin
         start <= 0;
         csr_valid <= 0;
      end else begin
         next_start = start;
         next_csr = csr_valid;
         if (start && !busy) begin
            expected_rsp.push_back(predict_graph_op(req_item));
            next_start = 0;
         end
         if (csr_valid && csr_ready) begin
            write_register(csr_index, csr_data);
            next_csr = 0;
         end
         if (!next_start && !next_csr) begin
            if (gap_cycles > 0) gap_cycles--;
            else if (pending.size() > 0) begin
               case (pending[0].kind)
                  PEND_REQ: begin
                     req_item <= pending[0].req;
                     next_start = 1;
                     void'(pending.pop_front());
                     if (pending.size() > 300 && $urandom_range(0, 9) == 0)
                        gap_cycles = $urandom_range(1, 19);
                  end
                  PEND_CSR: begin
                     if (expected_rsp.size() == 0 && !start) begin
                        csr_index <= pending[0].index;
                        csr_data <= pending[0].data;
                        next_csr = 1;
                        void'(pending.pop_front());
                     end
                  end
                  default: begin
                     if (expected_rsp.size() == 0 && !start) void'(pending.pop_front());
                  end
               endcase
            end
         end
         start <= next_start;
         csr_valid <= next_csr;
      end
   end

   // monitor
   always @(posedge clock) begin
      cgtb_pkg::rsp_type want;
      if (!reset && rsp_strobe) begin
         if (expected_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response %p", rsp_item);
         end else begin
            want = expected_rsp.pop_front();
            if (rsp_item !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"mismatch: expected od=%0d id=%0d off=%0d nb=%0d tot=%0d st=%0d,",
                            " got od=%0d id=%0d off=%0d nb=%0d tot=%0d st=%0d"},
                     want.out_degree, want.in_degree, want.offset, want.neighbor,
                     want.edge_total, want.status, rsp_item.out_degree,
                     rsp_item.in_degree, rsp_item.offset, rsp_item.neighbor,
                     rsp_item.edge_total, rsp_item.status);
            end
         end
      end
   end

   function automatic void push_request(logic [1:0] func, int node, int links, int tgt,
                                        int pos);
      pend_type p;
      p.kind = PEND_REQ;
      p.req.func = func;
      p.req.node_id = 10'(node);
      p.req.link_count = 13'(links);
      p.req.target = 10'(tgt);
      p.req.position = 12'(pos);
      p.index = '0;
      p.data = '0;
      pending.push_back(p);
      if (func == cgtb_pkg::FUNC_EDGE && int'(p.req.target) < gen_nodes) gen_edges++;
   endfunction

   function automatic void push_register(logic [7:0] index, int data);
      pend_type p;
      p.kind = PEND_CSR;
      p.req = '0;
      p.index = index;
      p.data = 11'(data);
      pending.push_back(p);
      if (index == cgtb_pkg::CSR_NODE_COUNT)
         gen_nodes = (data > 1024) ? 1024 : (data & 11'h7FF);
   endfunction

   function automatic void push_drain();
      pend_type p;
      p.kind = PEND_DRAIN;
      p.req = '0;
      p.index = '0;
      p.data = '0;
      pending.push_back(p);
   endfunction

   function automatic int pick_node();
      if (gen_nodes == 0 || $urandom_range(0, 19) == 0) return $urandom_range(0, 1023);
      return $urandom_range(0, gen_nodes - 1);
   endfunction

   function automatic int pick_links();
      return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 8191) : $urandom_range(0, 8);
   endfunction

   function automatic int pick_position();
      int top;
      top = (gen_edges + 3 > 4095) ? 4095 : gen_edges + 3;
      return ($urandom_range(0, 7) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, top);
   endfunction

   function automatic void random_phase(int count);
      int k;
      int r;
      k = 0;
      while (k < count) begin
         r = $urandom_range(0, 99);
         if (r < 40) begin
            push_request(cgtb_pkg::FUNC_NODE, pick_node(), pick_links(), $urandom, $urandom);
            k++;
            repeat ($urandom_range(0, 6)) begin
               push_request(cgtb_pkg::FUNC_EDGE, $urandom, $urandom, pick_node(), $urandom);
               k++;
            end
         end else if (r < 78) begin
            push_request(cgtb_pkg::FUNC_READ, pick_node(), $urandom, $urandom,
                         pick_position());
            k++;
         end else if (r < 81) begin
            push_request(cgtb_pkg::FUNC_BUILD, $urandom, $urandom, $urandom, $urandom);
            k++;
         end else if (r < 86) begin
            if ($urandom_range(0, 3) == 0) push_drain();
            push_request(cgtb_pkg::FUNC_EDGE, $urandom, $urandom, pick_node(), $urandom);
            k++;
         end else begin
            push_request(2'($urandom_range(0, 3)), $urandom, $urandom, $urandom, $urandom);
            k++;
         end
      end
   endfunction

   initial begin
      foreach (out_deg[i]) out_deg[i] = '0;
      foreach (in_deg[i]) in_deg[i] = '0;

      // directed requests
      push_request(cgtb_pkg::FUNC_READ, 0, 0, 0, 0);
      push_request(cgtb_pkg::FUNC_NODE, 0, 0, 0, 0);
      push_request(cgtb_pkg::FUNC_NODE, 1023, 8191, 1023, 4095);
      push_request(cgtb_pkg::FUNC_EDGE, 0, 0, 0, 0);
      push_request(cgtb_pkg::FUNC_EDGE, 1023, 8191, 1023, 4095);
      push_request(cgtb_pkg::FUNC_NODE, 5, 4096, 0, 0);
      push_request(cgtb_pkg::FUNC_EDGE, 0, 0, 1023, 0);
      push_request(cgtb_pkg::FUNC_EDGE, 0, 0, 5, 0);
      push_request(cgtb_pkg::FUNC_READ, 1023, 0, 0, 0);
      push_request(cgtb_pkg::FUNC_BUILD, 0, 0, 0, 0);
      push_request(cgtb_pkg::FUNC_READ, 1023, 0, 0, 0);
      push_request(cgtb_pkg::FUNC_READ, 5, 8191, 1023, 1);
      push_request(cgtb_pkg::FUNC_READ, 0, 0, 0, 4095);
      push_drain();
      push_register(cgtb_pkg::CSR_BUILD_INVERSE, 0);
      push_register(cgtb_pkg::CSR_NODE_COUNT, 4);
      push_request(cgtb_pkg::FUNC_NODE, 4, 3, 0, 0);
      push_request(cgtb_pkg::FUNC_EDGE, 0, 0, 4, 0);
      push_request(cgtb_pkg::FUNC_READ, 1023, 0, 0, 0);
      push_request(cgtb_pkg::FUNC_BUILD, 0, 0, 0, 0);
      push_request(cgtb_pkg::FUNC_READ, 0, 0, 0, 0);
      push_drain();
      push_register(cgtb_pkg::CSR_BUILD_INVERSE, 1);
      push_request(cgtb_pkg::FUNC_BUILD, 0, 0, 0, 0);
      push_request(cgtb_pkg::FUNC_READ, 3, 0, 0, 2);
      push_drain();
      push_register(cgtb_pkg::CSR_NODE_COUNT, 0);
      push_request(cgtb_pkg::FUNC_READ, 0, 0, 0, 0);
      push_request(cgtb_pkg::FUNC_NODE, 0, 1, 0, 0);

      // random phases over several settings
      push_drain();
      push_register(cgtb_pkg::CSR_NODE_COUNT, 16);
      push_register(cgtb_pkg::CSR_BUILD_INVERSE, 1);
      random_phase(300);
      push_drain();
      push_register(cgtb_pkg::CSR_NODE_COUNT, 1);
      random_phase(150);
      push_drain();
      push_register(cgtb_pkg::CSR_NODE_COUNT, 2047);
      push_register(cgtb_pkg::CSR_BUILD_INVERSE, 0);
      random_phase(150);
      push_drain();
      push_register(cgtb_pkg::CSR_BUILD_INVERSE, 1);
      push_register(cgtb_pkg::CSR_NODE_COUNT, $urandom_range(2, 64));
      random_phase(350);
      push_drain();
      push_register(cgtb_pkg::CSR_NODE_COUNT, 1024);
      random_phase(250);

      // final build over everything loaded
      push_request(cgtb_pkg::FUNC_BUILD, 0, 0, 0, 0);
      repeat (20)
         push_request(cgtb_pkg::FUNC_READ, $urandom_range(0, 1023), 0, 0,
                      $urandom_range(0, 4095));
      push_request(cgtb_pkg::FUNC_READ, 1023, 0, 0, 4095);

      repeat (10) @(posedge clock);
      reset <= 0;
      while (pending.size() != 0 || start || csr_valid || expected_rsp.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatches == 0 && expected_rsp.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   initial begin
      #50ms;
      $display("*** FAILED ***");
      $finish;
   end

endmodule
